@@ rtl/mbaprx_pkg.sv @@
`default_nettype none

package mbaprx_pkg;

  localparam int unsigned POS_W = 9;

  // Offsets of the header bytes, the function code and the first payload byte within a frame.
  localparam logic [POS_W-1:0] POS_TID_HI   = 9'd0;
  localparam logic [POS_W-1:0] POS_TID_LO   = 9'd1;
  localparam logic [POS_W-1:0] POS_PROTO_HI = 9'd2;
  localparam logic [POS_W-1:0] POS_PROTO_LO = 9'd3;
  localparam logic [POS_W-1:0] POS_LEN_HI   = 9'd4;
  localparam logic [POS_W-1:0] POS_LEN_LO   = 9'd5;
  localparam logic [POS_W-1:0] POS_UNIT     = 9'd6;
  localparam logic [POS_W-1:0] POS_FUNC     = 9'd7;
  localparam logic [POS_W-1:0] POS_PAYLOAD  = 9'd8;

  localparam logic [7:0]  PROTO_EXPECTED = 8'd0;
  localparam logic [15:0] MIN_LENGTH     = 16'd2;
  localparam logic [7:0]  PDU_MAX_RESET  = 8'd253;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_FLUSH = 1'b1
  } in_kind_t;

  typedef enum logic [1:0] {
    RES_PAYLOAD = 2'd0,
    RES_DONE    = 2'd1,
    RES_REJECT  = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [15:0] trans_id;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [7:0]  payload_count;
  } res_item_t;

endpackage

`default_nettype wire

@@ rtl/mbap_frame_receiver_core.sv @@
`default_nettype none

// MBAP receive deframer. Each item is one received stream byte or a flush
// command; the block gathers the 7-byte header, rejects bad headers with an
// error item, and otherwise emits one item per payload byte, the last one
// marked as frame complete; an empty payload's function code byte is itself
// the completion item. Unless stalled it takes one item per clock: an item
// passes an input register, one pass of header/payload decode logic, and an
// output register. A result that waits for res_ready holds the decode stage,
// which then holds the input; with res_ready high it takes an item every cycle.
// pdu_max resets to 253 and may only be written while no item is in flight.
module mbap_frame_receiver_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rx_valid,
  output logic                  rx_ready,
  input  mbaprx_pkg::rx_item_t  rx_item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output mbaprx_pkg::res_item_t res_item,
  input  logic                  pdu_max_we,
  input  logic [7:0]            pdu_max_wdata
);

  logic                  s1_valid;
  mbaprx_pkg::rx_item_t  s1_item;
  logic                  advance;
  logic                  hit;
  mbaprx_pkg::res_item_t result;
  logic [7:0]            pdu_max;

  // The decode stage moves on whenever the output register is free or is
  // being emptied in this cycle.
  assign advance  = s1_valid && (!res_valid || res_ready);
  assign rx_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_ready) begin
      s1_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      s1_item <= rx_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pdu_max <= mbaprx_pkg::PDU_MAX_RESET;
    end else if (pdu_max_we) begin
      pdu_max <= pdu_max_wdata;
    end
  end

  mbaprx_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (s1_item),
    .pdu_max (pdu_max),
    .hit     (hit),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= hit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      res_item <= result;
    end
  end

  a_reject_zero_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.result_kind == mbaprx_pkg::RES_REJECT) |->
      (res_item.function_code == 8'd0) && (res_item.payload_count == 8'd0) &&
      (res_item.payload_index == 8'd0))
    else $error("rejection item carries frame fields");

  a_payload_index_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.result_kind == mbaprx_pkg::RES_PAYLOAD) |->
      ({1'b0, res_item.payload_index} + 9'd1) < {1'b0, res_item.payload_count})
    else $error("payload item index past end of frame");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("decode stage lost a stalled item");

  a_result_kind_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_item.result_kind == mbaprx_pkg::RES_PAYLOAD) ||
      (res_item.result_kind == mbaprx_pkg::RES_DONE) ||
      (res_item.result_kind == mbaprx_pkg::RES_REJECT))
    else $error("result item with unused kind code");

endmodule

`default_nettype wire

@@ rtl/mbaprx_parse.sv @@
`default_nettype none

module mbaprx_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  mbaprx_pkg::rx_item_t item,
  input  logic [7:0]           pdu_max,
  output logic                 hit,
  output mbaprx_pkg::res_item_t result
);

  logic [mbaprx_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [15:0] held_transaction, held_transaction_next;
  logic        protocol_nonzero, protocol_nonzero_next;
  logic [15:0] held_length, held_length_next;
  logic [7:0]  held_unit, held_unit_next;
  logic [7:0]  held_function, held_function_next;

  logic [7:0]                   b;
  logic [7:0]                   plen;
  logic [mbaprx_pkg::POS_W-1:0] idx;
  logic                         last_byte;
  logic                         bad_header;

  assign b          = item.rx_byte;
  assign plen       = 8'(held_length - mbaprx_pkg::MIN_LENGTH);
  assign idx        = byte_position - mbaprx_pkg::POS_PAYLOAD;
  assign last_byte  = ({1'b0, idx} + 10'd1) >= {2'b00, plen};
  // The limit pdu_max+1 never exceeds 256, so 16 bits hold it.
  assign bad_header = protocol_nonzero || (held_length < mbaprx_pkg::MIN_LENGTH) ||
                      (held_length > ({8'd0, pdu_max} + 16'd1));

  always_comb begin
    byte_position_next    = byte_position;
    held_transaction_next = held_transaction;
    protocol_nonzero_next = protocol_nonzero;
    held_length_next      = held_length;
    held_unit_next        = held_unit;
    held_function_next    = held_function;
    hit                   = 1'b0;
    result                = '0;
    result.trans_id       = held_transaction;
    result.unit_id        = held_unit;

    if (item.kind == mbaprx_pkg::KIND_FLUSH) begin
      byte_position_next = mbaprx_pkg::POS_TID_HI;
    end else begin
      unique case (byte_position)
        mbaprx_pkg::POS_TID_HI: begin
          held_transaction_next = {b, 8'd0};
          byte_position_next    = mbaprx_pkg::POS_TID_LO;
        end
        mbaprx_pkg::POS_TID_LO: begin
          held_transaction_next = {held_transaction[15:8], b};
          byte_position_next    = mbaprx_pkg::POS_PROTO_HI;
        end
        mbaprx_pkg::POS_PROTO_HI: begin
          protocol_nonzero_next = (b != mbaprx_pkg::PROTO_EXPECTED);
          byte_position_next    = mbaprx_pkg::POS_PROTO_LO;
        end
        mbaprx_pkg::POS_PROTO_LO: begin
          protocol_nonzero_next = protocol_nonzero || (b != mbaprx_pkg::PROTO_EXPECTED);
          byte_position_next    = mbaprx_pkg::POS_LEN_HI;
        end
        mbaprx_pkg::POS_LEN_HI: begin
          held_length_next   = {b, 8'd0};
          byte_position_next = mbaprx_pkg::POS_LEN_LO;
        end
        mbaprx_pkg::POS_LEN_LO: begin
          held_length_next   = {held_length[15:8], b};
          byte_position_next = mbaprx_pkg::POS_UNIT;
        end
        mbaprx_pkg::POS_UNIT: begin
          held_unit_next = b;
          result.unit_id = b;
          if (bad_header) begin
            hit                = 1'b1;
            result.result_kind = mbaprx_pkg::RES_REJECT;
            byte_position_next = mbaprx_pkg::POS_TID_HI;
          end else begin
            byte_position_next = mbaprx_pkg::POS_FUNC;
          end
        end
        mbaprx_pkg::POS_FUNC: begin
          held_function_next = b;
          if (held_length == mbaprx_pkg::MIN_LENGTH) begin
            // Empty payload: the function code closes the frame.
            hit                  = 1'b1;
            result.result_kind   = mbaprx_pkg::RES_DONE;
            result.function_code = b;
            byte_position_next   = mbaprx_pkg::POS_TID_HI;
          end else begin
            byte_position_next = mbaprx_pkg::POS_PAYLOAD;
          end
        end
        default: begin
          hit                  = 1'b1;
          result.payload_byte  = b;
          result.payload_index = idx[7:0];
          result.function_code = held_function;
          result.payload_count = plen;
          if (last_byte) begin
            result.result_kind = mbaprx_pkg::RES_DONE;
            byte_position_next = mbaprx_pkg::POS_TID_HI;
          end else begin
            result.result_kind = mbaprx_pkg::RES_PAYLOAD;
            byte_position_next = byte_position + 9'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= mbaprx_pkg::POS_TID_HI;
      held_transaction <= '0;
      protocol_nonzero <= 1'b0;
      held_length      <= '0;
      held_unit        <= '0;
      held_function    <= '0;
    end else if (step) begin
      byte_position    <= byte_position_next;
      held_transaction <= held_transaction_next;
      protocol_nonzero <= protocol_nonzero_next;
      held_length      <= held_length_next;
      held_unit        <= held_unit_next;
      held_function    <= held_function_next;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/mbap_frame_receiver_core_tb.sv @@
`default_nettype none

module mbap_frame_receiver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEADER_BYTES = 7;
  localparam int FULL_FRAME   = 1024;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  rx_valid = 1'b0;
  logic                  rx_ready;
  mbaprx_pkg::rx_item_t  rx_item = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  mbaprx_pkg::res_item_t res_item;
  logic                  pdu_max_we = 1'b0;
  logic [7:0]            pdu_max_wdata = '0;

  // Expected deframer state, kept in step with every accepted item.
  logic [mbaprx_pkg::POS_W-1:0] frame_pos = mbaprx_pkg::POS_TID_HI;
  logic [15:0]                  cur_tid = '0;
  logic                         proto_bad = 1'b0;
  logic [15:0]                  cur_len = '0;
  logic [7:0]                   cur_unit = '0;
  logic [7:0]                   cur_func = '0;
  logic [7:0]                   pdu_limit = mbaprx_pkg::PDU_MAX_RESET;

  mbaprx_pkg::res_item_t records_due[$];
  int                    mismatches = 0;
  int                    items_sent = 0;
  bit                    gap_en = 1'b1;
  bit                    stall_en = 1'b1;
  int                    stall_left = 0;

  mbap_frame_receiver_core dut (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_ready      (rx_ready),
    .rx_item       (rx_item),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_item      (res_item),
    .pdu_max_we    (pdu_max_we),
    .pdu_max_wdata (pdu_max_wdata)
  );

  always #10 clk = ~clk;

  // Works out the record, if any, that one accepted item produces.
  function automatic bit decode_rx_item(input mbaprx_pkg::rx_item_t it,
                                        output mbaprx_pkg::res_item_t rec);
    logic [7:0]                   b;
    logic [7:0]                   plen;
    logic [mbaprx_pkg::POS_W-1:0] idx;
    b = it.rx_byte;
    rec = '0;
    if (it.kind == mbaprx_pkg::KIND_FLUSH) begin
      frame_pos = mbaprx_pkg::POS_TID_HI;
      return 1'b0;
    end
    case (frame_pos)
      mbaprx_pkg::POS_TID_HI: begin
        cur_tid = {b, 8'h00};
        frame_pos = mbaprx_pkg::POS_TID_LO;
      end
      mbaprx_pkg::POS_TID_LO: begin
        cur_tid[7:0] = b;
        frame_pos = mbaprx_pkg::POS_PROTO_HI;
      end
      mbaprx_pkg::POS_PROTO_HI: begin
        proto_bad = (b != mbaprx_pkg::PROTO_EXPECTED);
        frame_pos = mbaprx_pkg::POS_PROTO_LO;
      end
      mbaprx_pkg::POS_PROTO_LO: begin
        if (b != mbaprx_pkg::PROTO_EXPECTED) proto_bad = 1'b1;
        frame_pos = mbaprx_pkg::POS_LEN_HI;
      end
      mbaprx_pkg::POS_LEN_HI: begin
        cur_len = {b, 8'h00};
        frame_pos = mbaprx_pkg::POS_LEN_LO;
      end
      mbaprx_pkg::POS_LEN_LO: begin
        cur_len[7:0] = b;
        frame_pos = mbaprx_pkg::POS_UNIT;
      end
      mbaprx_pkg::POS_UNIT: begin
        cur_unit = b;
        if (proto_bad || cur_len < mbaprx_pkg::MIN_LENGTH ||
            cur_len > {8'h00, pdu_limit} + 16'd1) begin
          rec.result_kind = mbaprx_pkg::RES_REJECT;
          rec.trans_id = cur_tid;
          rec.unit_id = cur_unit;
          frame_pos = mbaprx_pkg::POS_TID_HI;
          return 1'b1;
        end
        frame_pos = mbaprx_pkg::POS_FUNC;
      end
      mbaprx_pkg::POS_FUNC: begin
        cur_func = b;
        if (cur_len == mbaprx_pkg::MIN_LENGTH) begin
          rec.result_kind = mbaprx_pkg::RES_DONE;
          rec.trans_id = cur_tid;
          rec.unit_id = cur_unit;
          rec.function_code = cur_func;
          frame_pos = mbaprx_pkg::POS_TID_HI;
          return 1'b1;
        end
        frame_pos = mbaprx_pkg::POS_PAYLOAD;
      end
      default: begin
        plen = 8'(cur_len - mbaprx_pkg::MIN_LENGTH);
        idx = frame_pos - mbaprx_pkg::POS_PAYLOAD;
        rec.payload_byte = b;
        rec.payload_index = idx[7:0];
        rec.trans_id = cur_tid;
        rec.unit_id = cur_unit;
        rec.function_code = cur_func;
        rec.payload_count = plen;
        // The last payload byte doubles as the completion record.
        if ({1'b0, idx} + 10'd1 >= {2'b00, plen}) begin
          rec.result_kind = mbaprx_pkg::RES_DONE;
          frame_pos = mbaprx_pkg::POS_TID_HI;
        end else begin
          rec.result_kind = mbaprx_pkg::RES_PAYLOAD;
          frame_pos = frame_pos + 9'd1;
        end
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    end
  endtask

  always @(posedge clk) begin : frame_tracking
    mbaprx_pkg::res_item_t rec;
    mbaprx_pkg::res_item_t want;
    if (!rst) begin
      if (rx_valid && rx_ready) begin
        if (decode_rx_item(rx_item, rec)) records_due.push_back(rec);
      end
      if (res_valid && res_ready) begin
        if (records_due.size() == 0) begin
          report_mismatch($sformatf("result item %h with none expected", res_item));
        end else begin
          want = records_due.pop_front();
          check_field("result_kind", 16'(want.result_kind), 16'(res_item.result_kind));
          check_field("payload_byte", 16'(want.payload_byte), 16'(res_item.payload_byte));
          check_field("payload_index", 16'(want.payload_index),
                      16'(res_item.payload_index));
          check_field("trans_id", want.trans_id, res_item.trans_id);
          check_field("unit_id", 16'(want.unit_id), 16'(res_item.unit_id));
          check_field("function_code", 16'(want.function_code),
                      16'(res_item.function_code));
          check_field("payload_count", 16'(want.payload_count),
                      16'(res_item.payload_count));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!stall_en) begin
      stall_left = 0;
    end else if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13);
    end
    if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left--;
    end else begin
      res_ready <= 1'b1;
    end
  end

  task automatic send_item(input mbaprx_pkg::rx_item_t it);
    int gap;
    gap = 0;
    if (gap_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      @(negedge clk);
      rx_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    rx_valid <= 1'b1;
    rx_item <= it;
    do @(posedge clk); while (!rx_ready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    mbaprx_pkg::rx_item_t it;
    it.kind = mbaprx_pkg::KIND_BYTE;
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_flush();
    mbaprx_pkg::rx_item_t it;
    it.kind = mbaprx_pkg::KIND_FLUSH;
    it.rx_byte = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  // Sends the frame's bytes in stream order, stopping after cut bytes.
  task automatic send_frame(input logic [15:0] tid, input logic [15:0] proto,
                            input logic [15:0] len, input logic [7:0] unit,
                            input logic [7:0] func, input int cut);
    logic [7:0] hdr [HEADER_BYTES];
    int total;
    hdr = '{tid[15:8], tid[7:0], proto[15:8], proto[7:0], len[15:8], len[7:0], unit};
    total = (len >= mbaprx_pkg::MIN_LENGTH) ? int'(len) + 6 : HEADER_BYTES;
    if (cut < total) total = cut;
    for (int i = 0; i < total; i++) begin
      if (i < HEADER_BYTES) send_byte(hdr[i]);
      else if (i == HEADER_BYTES) send_byte(func);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Holds the sender until every expected item is back and the pipeline is empty.
  task automatic wait_until_drained();
    @(negedge clk);
    rx_valid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_pdu_max(input logic [7:0] value);
    wait_until_drained();
    @(negedge clk);
    pdu_max_we <= 1'b1;
    pdu_max_wdata <= value;
    pdu_limit = value;
    @(negedge clk);
    pdu_max_we <= 1'b0;
  endtask

  task automatic random_frame();
    logic [15:0] tid;
    logic [7:0]  unit;
    logic [7:0]  func;
    int lim;
    int top;
    int len;
    int pick;
    tid = 16'($urandom);
    unit = 8'($urandom);
    func = 8'($urandom);
    lim = int'(pdu_limit) + 1;
    top = (lim < 18) ? lim : 18;
    len = ($urandom_range(0, 29) == 0) ? lim : int'($urandom_range(2, top));
    pick = $urandom_range(0, 19);
    if (pick < 13) begin
      send_frame(tid, 16'h0000, 16'(len), unit, func, FULL_FRAME);
    end else if (pick < 16) begin
      case ($urandom_range(0, 2))
        0: send_frame(tid, 16'($urandom_range(1, 65535)), 16'(len), unit, func,
                      HEADER_BYTES);
        1: send_frame(tid, 16'h0000, 16'($urandom_range(0, 1)), unit, func, HEADER_BYTES);
        default: send_frame(tid, 16'h0000, 16'($urandom_range(lim + 1, 65535)), unit, func,
                            HEADER_BYTES);
      endcase
    end else if (pick < 19) begin
      send_frame(tid, 16'h0000, 16'(len), unit, func, $urandom_range(1, len + 5));
      send_flush();
    end else begin
      // Unframed bytes, then a flush to get back in step.
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      send_flush();
    end
  endtask

  task automatic test_directed_frames();
    send_frame(16'hFFFF, 16'h0000, 16'd2, 8'hFF, 8'h00, FULL_FRAME);
    send_frame(16'h0000, 16'h8001, 16'd3, 8'h00, 8'hFF, HEADER_BYTES);
    send_frame(16'h1234, 16'h0000, 16'd1, 8'h5A, 8'h00, HEADER_BYTES);
    send_frame(16'hA5C3, 16'h0000, 16'd3, 8'h01, 8'hFF, 3);
    send_flush();
  endtask

  task automatic test_pdu_limits();
    set_pdu_max(8'd1);
    send_frame(16'h0F0F, 16'h0000, 16'd2, 8'h33, 8'h81, FULL_FRAME);
    send_frame(16'hF0F0, 16'h0000, 16'd3, 8'hCC, 8'h7E, HEADER_BYTES);
    // With a zero limit no length passes the check.
    set_pdu_max(8'd0);
    send_frame(16'h5555, 16'h0000, 16'd2, 8'hAA, 8'h01, HEADER_BYTES);
    set_pdu_max(mbaprx_pkg::PDU_MAX_RESET);
    send_frame(16'hAAAA, 16'h0000, 16'd255, 8'h55, 8'h02, HEADER_BYTES);
    send_frame(16'h8000, 16'h0000, 16'd0, 8'h80, 8'h03, HEADER_BYTES);
  endtask

  task automatic test_random_traffic();
    int phase_end;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_pdu_max(8'd1);
        1: set_pdu_max(8'($urandom_range(2, 40)));
        2: set_pdu_max(8'($urandom_range(1, 253)));
        default: set_pdu_max(8'd253);
      endcase
      phase_end = items_sent + 45;
      while (items_sent < phase_end) begin
        gap_en = ($urandom_range(0, 3) != 0);
        stall_en = ($urandom_range(0, 3) != 0);
        random_frame();
      end
    end
    gap_en = 1'b1;
    stall_en = 1'b1;
  endtask

  task automatic test_largest_frame();
    set_pdu_max(8'd253);
    send_frame(16'($urandom), 16'h0000, 16'd254, 8'($urandom), 8'($urandom), FULL_FRAME);
  endtask

  task automatic test_steady_stream();
    int stop_at;
    set_pdu_max(8'($urandom_range(1, 253)));
    gap_en = 1'b0;
    stall_en = 1'b0;
    stop_at = items_sent + 40;
    while (items_sent < stop_at) random_frame();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_pdu_limits();
    test_random_traffic();
    test_largest_frame();
    test_steady_stream();
    wait_until_drained();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
